/* src/fbdlp_pkg.sv */
// Package for the four-button debounce and long-press unit.
// Holds the word types, register map and reset constants; no dependencies.
`default_nettype none

package fbdlp_pkg;

	// Field widths of the sample and register words.
	localparam int STAMP_W = 32;
	localparam int DEB_W   = 16;
	localparam int HOLD_W  = 32;

	// Default width of the stored timestamps.
	localparam int TIME_BITS_DEF = 32;

	// Register reset values.
	localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 16'd50;
	localparam logic [HOLD_W-1:0] HOLD_RESET     = 32'd5000;

	// Configuration port: byte address width and register selector.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_HOLD     = 1'b1;

	// Button channels, in the order they are processed.
	localparam int NUM_BTN  = 4;
	localparam int BTN_FWD  = 0;
	localparam int BTN_REV  = 1;
	localparam int BTN_PWR  = 2;
	localparam int BTN_RST  = 3;

	// One input sample.
	typedef struct packed {
		logic [STAMP_W-1:0] now_ms;
		logic               raw_forward;
		logic               raw_reverse;
		logic               raw_power;
		logic               raw_restart;
		logic               power_on;
		logic               motor_running;
		logic               motor_reverse;
	} in_word_t;

	// One result word.
	typedef struct packed {
		logic start_forward;
		logic start_reverse;
		logic stop_motor;
		logic toggle_power;
		logic restart_now;
		logic hold_armed;
	} out_word_t;

endpackage

`default_nettype wire

/* src/fbdlp_if.sv */
// Valid/ready channel interfaces for samples and results.
// Depends on fbdlp_pkg for the word types.
`default_nettype none

// Sample channel.
interface fbdlp_in_if;
	import fbdlp_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface fbdlp_out_if;
	import fbdlp_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/fbdlp_cfg.sv */
// APB-style register block holding debounce_ms and hold_ms.
// Depends on fbdlp_pkg for the register map and reset values.
`default_nettype none

module fbdlp_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [fbdlp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [fbdlp_pkg::DATA_W-1:0] pwdata,
	output logic      [fbdlp_pkg::DATA_W-1:0] prdata,
	output logic                              pready,
	output logic      [fbdlp_pkg::DEB_W-1:0]  debounce_ms,
	output logic      [fbdlp_pkg::HOLD_W-1:0] hold_ms
);
	import fbdlp_pkg::*;

	logic [DEB_W-1:0]  debounce_q;
	logic [HOLD_W-1:0] hold_q;
	logic              wr_en;
	logic              reg_sel;

	// Registers sit on 4-byte boundaries; bit 2 selects one of the two.
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Register write on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			hold_q     <= HOLD_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_DEBOUNCE: debounce_q <= pwdata[DEB_W-1:0];
				REG_HOLD:     hold_q     <= pwdata[HOLD_W-1:0];
				default:      ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		case (reg_sel)
			REG_DEBOUNCE: prdata = DATA_W'(debounce_q);
			REG_HOLD:     prdata = DATA_W'(hold_q);
			default:      prdata = '0;
		endcase
	end

	assign debounce_ms = debounce_q;
	assign hold_ms     = hold_q;

endmodule

`default_nettype wire

/* src/fbdlp_chan.sv */
// Debounce state for one button: last raw level, accepted level, change time.
// Depends on fbdlp_pkg for the debounce register width.
`default_nettype none

module fbdlp_chan #(
	parameter int TIME_BITS = fbdlp_pkg::TIME_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        clr,
	input  wire logic [TIME_BITS-1:0]        now,
	input  wire logic                        raw,
	input  wire logic [fbdlp_pkg::DEB_W-1:0] debounce_ms,
	output logic                             accept
);
	import fbdlp_pkg::*;

	logic                 prev_q;
	logic                 stable_q;
	logic [TIME_BITS-1:0] change_q;
	logic [TIME_BITS-1:0] elapsed;
	logic                 raw_moved;

	// A raw change restarts the timer and is itself excluded from acceptance,
	// so a moving level can never pass the threshold in the same sample.
	assign raw_moved = (raw != prev_q);
	assign elapsed   = now - change_q;
	assign accept    = !raw_moved && (elapsed > TIME_BITS'(debounce_ms)) &&
	                   (raw != stable_q);

	// State update per enabled sample; a restart returns to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b1;
			stable_q <= 1'b1;
			change_q <= '0;
		end else if (en) begin
			if (clr) begin
				prev_q   <= 1'b1;
				stable_q <= 1'b1;
				change_q <= '0;
			end else begin
				prev_q <= raw;
				if (raw_moved) begin
					change_q <= now;
				end
				if (accept) begin
					stable_q <= raw;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* src/fbdlp_act.sv */
// Command decode for accepted button edges and the reset-button hold timer.
// Depends on fbdlp_pkg for the word types and button indexes.
`default_nettype none

module fbdlp_act #(
	parameter int TIME_BITS = fbdlp_pkg::TIME_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            en,
	input  wire logic [TIME_BITS-1:0]            now,
	input  wire logic [fbdlp_pkg::HOLD_W-1:0]    hold_ms,
	input  wire logic [fbdlp_pkg::NUM_BTN-1:0]   accept,
	input  wire fbdlp_pkg::in_word_t             word,
	output fbdlp_pkg::out_word_t                 res
);
	import fbdlp_pkg::*;

	localparam int CMP_W = (TIME_BITS > HOLD_W) ? TIME_BITS : HOLD_W;

	logic                 armed_q;
	logic [TIME_BITS-1:0] armed_time_q;
	logic                 run_fwd;
	logic                 dir_fwd;
	logic                 arm_set;
	logic                 arm_clr;
	logic                 armed_nxt;
	logic                 held_long;
	logic [TIME_BITS-1:0] held;

	// Motor commands: the reverse release check sees the motor status as
	// left by this sample's forward action.
	always_comb begin
		res               = '0;
		run_fwd           = word.motor_running;
		dir_fwd           = word.motor_reverse;
		if (accept[BTN_FWD]) begin
			if (!word.raw_forward) begin
				if (word.power_on) begin
					res.start_forward = 1'b1;
					run_fwd           = 1'b1;
					dir_fwd           = 1'b0;
				end
			end else if (word.motor_running && !word.motor_reverse) begin
				res.stop_motor = 1'b1;
				run_fwd        = 1'b0;
			end
		end
		if (accept[BTN_REV]) begin
			if (!word.raw_reverse) begin
				res.start_reverse = word.power_on;
			end else if (run_fwd && dir_fwd) begin
				res.stop_motor = 1'b1;
			end
		end
		res.toggle_power = accept[BTN_PWR] && !word.raw_power;
		res.restart_now  = held_long;
		res.hold_armed   = armed_nxt && !held_long;
	end

	// Hold timer. A fresh press stamps the current time and is excluded from
	// the expiry check, so it cannot expire in the same sample.
	assign arm_set   = accept[BTN_RST] && !word.raw_restart;
	assign arm_clr   = accept[BTN_RST] && word.raw_restart;
	assign armed_nxt = arm_set || (armed_q && !arm_clr);
	assign held      = now - armed_time_q;
	assign held_long = armed_nxt && !arm_set && (CMP_W'(held) > CMP_W'(hold_ms));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			armed_time_q <= '0;
		end else if (en) begin
			if (held_long) begin
				armed_q      <= 1'b0;
				armed_time_q <= '0;
			end else begin
				armed_q <= armed_nxt;
				if (arm_set) begin
					armed_time_q <= now;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* src/four_button_debounce_long_press_unit.sv */
// Four-button debounce and long-press unit. It takes one sample word per clock
// cycle while the output is not stalled and returns exactly one result word
// per sample, in order. A sample is captured in an input register; when it
// advances, the four debounce channels, the command decode and the hold timer
// update their state and load the result register, and the input register may
// take the next word at the same time. The per-channel timestamp subtract and
// compare sit between the two registers. A held result stalls the input only
// when both registers are full. Registers: debounce_ms at byte address 0,
// hold_ms at byte address 4; write them only while no sample is in flight.
// TIME_BITS sets the width of the stored timestamps; time differences wrap
// modulo 2^TIME_BITS.
// Depends on fbdlp_pkg, fbdlp_if, fbdlp_cfg, fbdlp_chan and fbdlp_act.
`default_nettype none

module four_button_debounce_long_press_unit #(
	parameter int TIME_BITS = fbdlp_pkg::TIME_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [fbdlp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [fbdlp_pkg::DATA_W-1:0] pwdata,
	output logic      [fbdlp_pkg::DATA_W-1:0] prdata,
	output logic                              pready,
	fbdlp_in_if.sink                          in_ch,
	fbdlp_out_if.source                       out_ch
);
	import fbdlp_pkg::*;

	logic                 valid_s1;
	in_word_t             data_s1;
	logic                 out_valid_q;
	out_word_t            out_data_q;
	logic                 out_free;
	logic                 adv;
	logic [TIME_BITS-1:0] now;
	logic [DEB_W-1:0]     debounce_ms;
	logic [HOLD_W-1:0]    hold_ms;
	logic [NUM_BTN-1:0]   raw_vec;
	logic [NUM_BTN-1:0]   accept;
	out_word_t            res;

	// Registers.
	fbdlp_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.debounce_ms (debounce_ms),
		.hold_ms     (hold_ms)
	);

	// Handshake: the sample register moves on whenever the result register
	// is empty or being drained this cycle.
	assign out_free    = !out_valid_q || out_ch.ready;
	assign adv         = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_s1 <= in_ch.data;
		end
	end

	// Sample fields for the channels.
	assign now = TIME_BITS'(data_s1.now_ms);
	always_comb begin
		raw_vec          = '1;
		raw_vec[BTN_FWD] = data_s1.raw_forward;
		raw_vec[BTN_REV] = data_s1.raw_reverse;
		raw_vec[BTN_PWR] = data_s1.raw_power;
		raw_vec[BTN_RST] = data_s1.raw_restart;
	end

	// One debounce channel per button.
	for (genvar i = 0; i < NUM_BTN; i++) begin : g_chan
		fbdlp_chan #(
			.TIME_BITS (TIME_BITS)
		) u_chan (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (adv),
			.clr         (res.restart_now),
			.now         (now),
			.raw         (raw_vec[i]),
			.debounce_ms (debounce_ms),
			.accept      (accept[i])
		);
	end

	// Commands and hold timer.
	fbdlp_act #(
		.TIME_BITS (TIME_BITS)
	) u_act (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.now     (now),
		.hold_ms (hold_ms),
		.accept  (accept),
		.word    (data_s1),
		.res     (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;

endmodule

`default_nettype wire

/* src/fbdlp_check.sv */
// Port-level checks for the four-button debounce unit, bound to the top level.
// Depends on fbdlp_pkg and four_button_debounce_long_press_unit.
`default_nettype none

module fbdlp_check (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 pready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire fbdlp_pkg::out_word_t out_data
);
	import fbdlp_pkg::*;

	// A restart returns the hold timer to its idle state in the same word.
	a_restart_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.restart_now |-> !out_data.hold_armed)
		else $error("restart word still shows the hold timer armed");

	// The register port never inserts wait states.
	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

	// A stalled result word stays offered.
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word withdrawn while stalled");

	// A stalled result word keeps its value.
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result word changed while stalled");

endmodule

bind four_button_debounce_long_press_unit fbdlp_check u_fbdlp_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

`default_nettype wire
